>>> rtl/assert_macros.svh
// Assertion macros shared by the directory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define LKCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define LKCD_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

>>> rtl/lkcd_pkg.sv
// Package with the shared constants and types of the LRU key directory.
`default_nettype none

package lkcd_pkg;

    // Default number of directory slots.
    localparam int unsigned LKCD_ENTRIES = 16;

    // Key geometry: four 64-bit words make one 256-bit key.
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned KEY_W     = WORD_W * KEY_WORDS;

    // Widths of the result fields.
    localparam int unsigned SLOT_OUT_W = 4;
    localparam int unsigned OCC_OUT_W  = 5;

    // Slot and rank width for the default directory size.
    localparam int unsigned LKCD_SLOT_W = $clog2(LKCD_ENTRIES);

    typedef enum logic {
        FUNC_LOOKUP = 1'b0,
        FUNC_INSERT = 1'b1
    } func_t;

    // Scan record that travels down the chain of cells.
    typedef struct packed {
        logic                   hit;
        logic [LKCD_SLOT_W-1:0] hit_slot;
        logic [LKCD_SLOT_W-1:0] hit_rank;
        logic [LKCD_SLOT_W-1:0] vic_slot;
    } lkcd_rec_t;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic                   en;
        logic                   write_key;
        logic                   age_all;
        logic [LKCD_SLOT_W-1:0] target;
        logic [LKCD_SLOT_W-1:0] limit;
    } lkcd_cmd_t;

endpackage

`default_nettype wire

>>> rtl/lru_key_cache_directory.sv
// Top level of the fully associative LRU directory of 256-bit keys.
// An accepted input beat is registered; the scan record then moves one cell per
// cycle down the chain of ENTRIES slot cells, and the update fills the output
// register once it is free. A new beat is taken only after the update.
// Reset clears every valid bit, every recency rank, the fill count and the
// output register; stored keys are not cleared and are only compared when valid.
`default_nettype none
`include "assert_macros.svh"

module lru_key_cache_directory #(
    parameter int unsigned ENTRIES = lkcd_pkg::LKCD_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input channel.
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [lkcd_pkg::WORD_W-1:0]     key_word_0,
    input  logic [lkcd_pkg::WORD_W-1:0]     key_word_1,
    input  logic [lkcd_pkg::WORD_W-1:0]     key_word_2,
    input  logic [lkcd_pkg::WORD_W-1:0]     key_word_3,
    // Result channel.
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [lkcd_pkg::SLOT_OUT_W-1:0] slot,
    output logic                            evicted,
    output logic [lkcd_pkg::OCC_OUT_W-1:0]  occupancy
);
    import lkcd_pkg::*;

    // Slot numbers and recency ranks share one width; the fill count must
    // also be able to hold ENTRIES itself.
    localparam int unsigned SLOT_W = $clog2(ENTRIES);
    localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [SLOT_W-1:0] hit_rank;
        logic [SLOT_W-1:0] vic_slot;
    } rec_t;

    typedef struct packed {
        logic              en;
        logic              write_key;
        logic              age_all;
        logic [SLOT_W-1:0] target;
        logic [SLOT_W-1:0] limit;
    } cmd_t;

    // IDLE takes a beat, SCAN waits for the record to reach the last cell,
    // and UPD waits for a free output register, then applies the update and fills it.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [CNT_W-1:0]  scan_cnt_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              func_reg;
    logic              func_next;
    logic [KEY_W-1:0]  query_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;
    logic              hit_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              evicted_reg;
    logic              evicted_next;
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;

    logic              accept;
    logic              out_free;
    cmd_t              cmd;
    rec_t              chain [ENTRIES];
    rec_t              tail;
    logic [ENTRIES-1:0] valid_vec;
    logic [31:0]       slot_wide;
    logic [31:0]       occ_wide;

    // The block takes a new beat only between items, but it does so even
    // while the previous result still waits in the output register.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // The chain of slot cells. Cell 0 starts from an empty record, and each
    // cell hands its registered record to the next one every cycle. The
    // query key and the update command are broadcast to all cells.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        rec_t rec_in;

        if (i == 0)
        begin : g_head
            assign rec_in = '0;
        end
        else
        begin : g_link
            assign rec_in = chain[i - 1];
        end

        lkcd_cell #(
            .ENTRIES (ENTRIES),
            .INDEX   (i),
            .rec_t   (rec_t),
            .cmd_t   (cmd_t)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .query   (query_reg),
            .cmd     (cmd),
            .rec_in  (rec_in),
            .rec_out (chain[i]),
            .valid   (valid_vec[i])
        );
    end

    assign tail = chain[ENTRIES - 1];

    // Sequencer and result logic. Valid slots always form the range from
    // slot 0 up to the fill count, because slots are filled lowest first and
    // never freed; the free slot for an insert is therefore the fill count.
    // A hit ages only the entries that were more recent than the hit entry.
    // A new insert ages every other valid entry: on a fill they all move one
    // step older, and on an eviction the victim holds the oldest rank so all
    // others are below it anyway.
    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        count_next     = count_reg;
        func_next      = func_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        evicted_next   = evicted_reg;
        occ_next       = occ_reg;
        cmd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next     = func;
                    scan_cnt_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == FULL)
                begin
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                if (out_free)
                begin
                    hit_next     = tail.hit;
                    evicted_next = 1'b0;
                    slot_next    = '0;
                    if (tail.hit)
                    begin
                        cmd.en     = 1'b1;
                        cmd.target = tail.hit_slot;
                        cmd.limit  = tail.hit_rank;
                        slot_next  = tail.hit_slot;
                    end
                    else if (func_reg == FUNC_INSERT)
                    begin
                        cmd.en        = 1'b1;
                        cmd.write_key = 1'b1;
                        cmd.age_all   = 1'b1;
                        if (count_reg != FULL)
                        begin
                            cmd.target = SLOT_W'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            cmd.target   = tail.vic_slot;
                            evicted_next = 1'b1;
                        end
                        slot_next = cmd.target;
                    end
                    occ_next       = count_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            func_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            slot_reg      <= '0;
            evicted_reg   <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            count_reg     <= count_next;
            func_reg      <= func_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            slot_reg      <= slot_next;
            evicted_reg   <= evicted_next;
            occ_reg       <= occ_next;
        end
    end

    // The query key is payload and holds from acceptance to the update.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg <= {key_word_3, key_word_2, key_word_1, key_word_0};
        end
    end

    // Slot and occupancy are reported at their fixed field widths, cut down
    // or zero-extended from the internal widths.
    assign slot_wide = 32'(slot_reg);
    assign occ_wide  = 32'(occ_reg);

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign slot      = slot_wide[SLOT_OUT_W-1:0];
    assign evicted   = evicted_reg;
    assign occupancy = occ_wide[OCC_OUT_W-1:0];

    // The fill count never passes the number of slots.
    `LKCD_ASSERT(a_count_range, clk, rst_n, (count_reg <= FULL), "fill count beyond slot count")
    // The fill count always equals the number of valid cells.
    `LKCD_ASSERT(a_valid_count, clk, rst_n, ($countones(valid_vec) == 32'(count_reg)), "valid bits disagree with fill count")
    // An eviction is only ever reported with a full directory.
    `LKCD_ASSERT_IMPL(a_evict_full, clk, rst_n, out_valid_reg && evicted_reg, count_reg == FULL, "eviction reported while not full")

endmodule

`default_nettype wire

>>> rtl/lkcd_cell.sv
// One directory slot: key, valid bit, recency rank and one stage of the scan chain.
`default_nettype none

module lkcd_cell #(
    parameter int unsigned ENTRIES = lkcd_pkg::LKCD_ENTRIES,
    parameter int unsigned INDEX   = 0,
    parameter type rec_t = lkcd_pkg::lkcd_rec_t,
    parameter type cmd_t = lkcd_pkg::lkcd_cmd_t
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lkcd_pkg::KEY_W-1:0] query,
    input  cmd_t                       cmd,
    input  rec_t                       rec_in,
    output rec_t                       rec_out,
    output logic                       valid
);
    import lkcd_pkg::*;

    localparam int unsigned     SLOT_W  = $clog2(ENTRIES);
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);
    localparam logic [SLOT_W-1:0] OLDEST  = SLOT_W'(ENTRIES - 1);

    logic [KEY_W-1:0]  key_reg;
    logic              valid_reg;
    logic              valid_next;
    logic [SLOT_W-1:0] rank_reg;
    logic [SLOT_W-1:0] rank_next;
    logic              match_reg;
    logic              match_next;
    rec_t              rec_reg;
    rec_t              rec_next;
    logic              selected;

    assign selected   = cmd.en && (cmd.target == MY_SLOT);
    assign match_next = valid_reg && (key_reg == query);

    // The selected slot becomes the most recent; other valid slots age when
    // they were more recent than the limit, or always on a new insert.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (selected)
        begin
            valid_next = 1'b1;
            rank_next  = '0;
        end
        else if (cmd.en && valid_reg && (cmd.age_all || (rank_reg < cmd.limit)))
        begin
            rank_next = rank_reg + 1'b1;
        end
    end

    // Keys are unique among valid slots, and so is the oldest rank when the
    // directory is full, so each cell simply overwrites its part of the record.
    always_comb
    begin
        rec_next = rec_in;
        if (match_reg)
        begin
            rec_next.hit      = 1'b1;
            rec_next.hit_slot = MY_SLOT;
            rec_next.hit_rank = rank_reg;
        end
        if (valid_reg && (rank_reg == OLDEST))
        begin
            rec_next.vic_slot = MY_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
            rec_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            match_reg <= match_next;
            rec_reg   <= rec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (selected && cmd.write_key)
        begin
            key_reg <= query;
        end
    end

    assign rec_out = rec_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire
